// File: sv/gev_pkg.sv
`default_nettype none

package gev_pkg;

	// Four stick axes, each with a low and a high direction.
	localparam int NUM_AXES       = 4;
	localparam int AXIS_EVENTS    = 2 * NUM_AXES;
	localparam int AXIS_W         = 8;
	localparam int INPUT_BUTTONS  = 16;
	localparam int CODE_W         = 5;
	localparam int AXIS_CODE_BASE = 16;

	localparam logic [AXIS_W-1:0] AXIS_RESET        = 8'd127;
	localparam logic [AXIS_W-1:0] LOWER_THRESH_INIT = 8'd50;
	localparam logic [AXIS_W-1:0] UPPER_THRESH_INIT = 8'd200;

	// Configuration register indexes.
	localparam logic CFG_LOWER_THRESHOLD = 1'b0;
	localparam logic CFG_UPPER_THRESHOLD = 1'b1;

	// Events found by one axis lane.
	typedef struct packed {
		logic high_press;
		logic high_chg;
		logic low_press;
		logic low_chg;
	} axis_evt_t;

endpackage

`default_nettype wire

// File: sv/gev_axis_lane.sv
`default_nettype none

// Compares one axis against both thresholds, now and before.
module gev_axis_lane (
	input  wire logic [gev_pkg::AXIS_W-1:0] now_val,
	input  wire logic [gev_pkg::AXIS_W-1:0] was_val,
	input  wire logic [gev_pkg::AXIS_W-1:0] lower_threshold,
	input  wire logic [gev_pkg::AXIS_W-1:0] upper_threshold,
	output gev_pkg::axis_evt_t              evt
);

	logic now_low, was_low, now_high, was_high;

	always_comb begin
		now_low  = now_val <= lower_threshold;
		was_low  = was_val <= lower_threshold;
		now_high = now_val >= upper_threshold;
		was_high = was_val >= upper_threshold;

		evt.low_chg    = now_low ^ was_low;
		evt.low_press  = now_low;
		evt.high_chg   = now_high ^ was_high;
		evt.high_press = now_high;
	end

endmodule

`default_nettype wire

// File: sv/gev_serializer.sv
`default_nettype none

// Holds the events of one sample and hands them out lowest position first.
// Positions below the axis event count are axis codes, the rest are buttons.
module gev_serializer #(
	parameter int EV_W = 24
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire logic [EV_W-1:0]            load_vec,
	input  wire logic [EV_W-1:0]            load_press,
	output logic                            empty_next,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            is_press,
	output logic [gev_pkg::CODE_W-1:0]      event_code,
	output logic                            last
);

	localparam int IDX_W = $clog2(EV_W);

	logic [EV_W-1:0]  vec_q;
	logic [EV_W-1:0]  press_q;
	logic [EV_W-1:0]  pick;
	logic [EV_W-1:0]  rest;
	logic [IDX_W-1:0] pick_idx;
	logic             beat;

	always_comb begin
		pick     = vec_q & (~vec_q + EV_W'(1));
		rest     = vec_q & ~pick;
		pick_idx = '0;
		for (int i = 0; i < EV_W; i++) begin
			if (pick[i]) begin
				pick_idx = pick_idx | IDX_W'(i);
			end
		end
		out_valid = |vec_q;
		is_press  = |(press_q & pick);
		last      = ~|rest;
		beat      = out_valid && out_ready;
		empty_next = !out_valid || (beat && last);
		if (pick_idx < IDX_W'(gev_pkg::AXIS_EVENTS)) begin
			event_code = gev_pkg::CODE_W'(pick_idx) + gev_pkg::CODE_W'(gev_pkg::AXIS_CODE_BASE);
		end else begin
			event_code = gev_pkg::CODE_W'(pick_idx - IDX_W'(gev_pkg::AXIS_EVENTS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_q <= '0;
		end else if (load) begin
			vec_q <= load_vec;
		end else if (beat) begin
			vec_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			press_q <= load_press;
		end
	end

endmodule

`default_nettype wire

// File: sv/gamepad_event_generator.sv
// Gamepad event generator.
// Input channel (in_valid/in_ready): one gamepad sample per beat. A sample
// with sample_valid low is accepted and dropped without touching the stored
// state. Output channel (out_valid/out_ready): one key event per beat, with
// last set on the final event of a sample; a sample with no change yields
// no beat at all. Configuration channel (cfg_valid/cfg_ready) writes the
// lower (index 0) or upper (index 1) threshold and is always ready.
// Four axis lanes and one lane per watched button compare the sample with
// the stored state in the cycle it is accepted, and the stored state moves
// on at once. The found events wait in a one-entry buffer and then in the
// serialiser, which issues the lowest pending event each cycle that
// out_ready is high. A sample's events are registered in the buffer and
// then in the serialiser before the first appears. A sample gives up to 24
// events, one per beat; a new sample is taken every cycle while the buffer
// can drain, so the output rate of one event a cycle sets the pace. When
// the receiver stalls, the serialiser holds its event, the buffer fills
// and in_ready falls. Reset clears the pressed set, centres the stored
// axes at 127 and restores thresholds 50 and 200.
`default_nettype none

module gamepad_event_generator #(
	parameter int NUM_BUTTONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        sample_valid,
	input  wire logic [15:0] buttons_raw,
	input  wire logic [7:0]  right_x,
	input  wire logic [7:0]  right_y,
	input  wire logic [7:0]  left_x,
	input  wire logic [7:0]  left_y,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_press,
	output logic [4:0]       event_code,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	// Only the buttons that exist on the input can be watched.
	localparam int WATCHED = (NUM_BUTTONS < gev_pkg::INPUT_BUTTONS) ?
		NUM_BUTTONS : gev_pkg::INPUT_BUTTONS;
	localparam int EV_W = gev_pkg::AXIS_EVENTS + WATCHED;

	logic [gev_pkg::AXIS_W-1:0] lower_q;
	logic [gev_pkg::AXIS_W-1:0] upper_q;
	logic [gev_pkg::AXIS_W-1:0] prev_axes_q [gev_pkg::NUM_AXES];
	logic [WATCHED-1:0]         prev_pressed_q;

	logic [gev_pkg::AXIS_W-1:0] now_axes [gev_pkg::NUM_AXES];
	gev_pkg::axis_evt_t         axis_evt [gev_pkg::NUM_AXES];
	logic [WATCHED-1:0]         pressed;

	logic [EV_W-1:0] found_vec;
	logic [EV_W-1:0] found_press;

	// One-entry buffer between the lanes and the serialiser.
	logic            pend_valid_s1;
	logic [EV_W-1:0] pend_vec_s1;
	logic [EV_W-1:0] pend_press_s1;

	logic in_beat;
	logic take_sample;
	logic ser_empty_next;
	logic ser_load;

	assign cfg_ready = 1'b1;

	assign now_axes[0] = right_x;
	assign now_axes[1] = right_y;
	assign now_axes[2] = left_x;
	assign now_axes[3] = left_y;

	for (genvar a = 0; a < gev_pkg::NUM_AXES; a++) begin : g_axis
		gev_axis_lane u_lane (
			.now_val         (now_axes[a]),
			.was_val         (prev_axes_q[a]),
			.lower_threshold (lower_q),
			.upper_threshold (upper_q),
			.evt             (axis_evt[a])
		);
	end

	// The button bits are active low; the stored set is active high.
	assign pressed = ~buttons_raw[WATCHED-1:0];

	always_comb begin
		for (int a = 0; a < gev_pkg::NUM_AXES; a++) begin
			found_vec[2*a]     = axis_evt[a].low_chg;
			found_vec[2*a+1]   = axis_evt[a].high_chg;
			found_press[2*a]   = axis_evt[a].low_press;
			found_press[2*a+1] = axis_evt[a].high_press;
		end
		for (int b = 0; b < WATCHED; b++) begin
			found_vec[gev_pkg::AXIS_EVENTS+b]   = pressed[b] ^ prev_pressed_q[b];
			found_press[gev_pkg::AXIS_EVENTS+b] = pressed[b];
		end
	end

	assign ser_load    = pend_valid_s1 && ser_empty_next;
	assign in_ready    = !pend_valid_s1 || ser_load;
	assign in_beat     = in_valid && in_ready;
	assign take_sample = in_beat && sample_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= gev_pkg::LOWER_THRESH_INIT;
			upper_q <= gev_pkg::UPPER_THRESH_INIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gev_pkg::CFG_LOWER_THRESHOLD: lower_q <= cfg_data;
				gev_pkg::CFG_UPPER_THRESHOLD: upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pressed_q <= '0;
			for (int a = 0; a < gev_pkg::NUM_AXES; a++) begin
				prev_axes_q[a] <= gev_pkg::AXIS_RESET;
			end
		end else if (take_sample) begin
			prev_pressed_q <= pressed;
			for (int a = 0; a < gev_pkg::NUM_AXES; a++) begin
				prev_axes_q[a] <= now_axes[a];
			end
		end
	end

	// A sample with no change never enters the buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_s1 <= 1'b0;
		end else if (take_sample && (|found_vec)) begin
			pend_valid_s1 <= 1'b1;
		end else if (ser_load) begin
			pend_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_sample && (|found_vec)) begin
			pend_vec_s1   <= found_vec;
			pend_press_s1 <= found_press;
		end
	end

	gev_serializer #(
		.EV_W (EV_W)
	) u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (ser_load),
		.load_vec   (pend_vec_s1),
		.load_press (pend_press_s1),
		.empty_next (ser_empty_next),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.is_press   (is_press),
		.event_code (event_code),
		.last       (last)
	);

	// The buffer never holds a sample without events.
	a_pend_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_s1 |-> (|pend_vec_s1))
		else $error("event buffer holds an empty sample");

	// A dropped sample leaves the stored buttons and the first and last stored axes alone.
	a_invalid_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && !sample_valid) |=> ($stable(prev_pressed_q) && $stable(prev_axes_q[0])
			&& $stable(prev_axes_q[3])))
		else $error("invalid sample changed stored state");

	// Events of a sample continue until last.
	a_more_after_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> out_valid)
		else $error("sample events stopped before last");

	// Codes stay within the defined set.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_code < 5'd24))
		else $error("event code out of range");

	// Input is refused only while the buffer is full and cannot drain.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (pend_valid_s1 && out_valid))
		else $error("input stalled without cause");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`default_nettype none

// Self-checking bench for the gamepad event generator.
// Pad samples, threshold writes, drain points and idling phases sit in one
// queue of pending actions. A clocked driver feeds the block from that
// queue, and a clocked monitor checks every event beat against the events
// that the bench has worked out for itself.
module testbench;

	// Bus and handshake timing.
	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 7;
	// Cycles of quiet after the last expected event before a threshold write.
	// The block registers events in its buffer and then its serialiser, so this
	// is ample cover for samples still in flight that cause no event.
	localparam int DRAIN_SETTLE = 8;
	localparam int TAIL_CYCLES  = 20;
	localparam int MAX_REPORTS  = 10;
	localparam int PHASE_ITEMS  = 52;

	typedef enum logic [1:0] {
		ACT_SAMPLE,
		ACT_CFG,
		ACT_DRAIN,
		ACT_PHASE
	} pad_act_t;

	// One pending action. The axes run right_x, right_y, left_x, left_y.
	typedef struct packed {
		pad_act_t                                         kind;
		logic                                             sample_valid;
		logic [gev_pkg::INPUT_BUTTONS-1:0]                buttons;
		logic [gev_pkg::NUM_AXES-1:0][gev_pkg::AXIS_W-1:0] axes;
		logic                                             cfg_idx;
		logic [gev_pkg::AXIS_W-1:0]                       cfg_val;
		logic [6:0]                                       idle_pct;
		logic [6:0]                                       stall_pct;
	} pad_action_t;

	typedef struct packed {
		logic                       is_press;
		logic [gev_pkg::CODE_W-1:0] code;
		logic                       last;
	} key_event_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Every block input starts at a known value.
	logic                       in_valid     = 1'b0;
	logic                       in_ready;
	logic                       sample_valid = 1'b0;
	logic [15:0]                buttons_raw  = '1;
	logic [7:0]                 right_x      = gev_pkg::AXIS_RESET;
	logic [7:0]                 right_y      = gev_pkg::AXIS_RESET;
	logic [7:0]                 left_x       = gev_pkg::AXIS_RESET;
	logic [7:0]                 left_y       = gev_pkg::AXIS_RESET;
	logic                       out_valid;
	logic                       out_ready    = 1'b0;
	logic                       is_press;
	logic [gev_pkg::CODE_W-1:0] event_code;
	logic                       last;
	logic                       cfg_valid    = 1'b0;
	logic                       cfg_ready;
	logic                       cfg_index    = gev_pkg::CFG_LOWER_THRESHOLD;
	logic [7:0]                 cfg_data     = '0;

	gamepad_event_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_valid (sample_valid),
		.buttons_raw  (buttons_raw),
		.right_x      (right_x),
		.right_y      (right_y),
		.left_x       (left_x),
		.left_y       (left_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_press     (is_press),
		.event_code   (event_code),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	pad_action_t pending[$];
	key_event_t  key_events_due[$];
	int          faults = 0;

	// Idling odds, in percent, for the phase under way.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	// The bench's own copy of the block state and thresholds.
	logic [gev_pkg::INPUT_BUTTONS-1:0]                 held_buttons;
	logic [gev_pkg::NUM_AXES-1:0][gev_pkg::AXIS_W-1:0] held_axes;
	logic [gev_pkg::AXIS_W-1:0]                        lower_thr;
	logic [gev_pkg::AXIS_W-1:0]                        upper_thr;

	// What the stimulus generator believes the block holds; it only steers
	// the random choices towards the thresholds and towards small changes.
	logic [gev_pkg::INPUT_BUTTONS-1:0]                 gen_buttons = '1;
	logic [gev_pkg::NUM_AXES-1:0][gev_pkg::AXIS_W-1:0] gen_axes    =
		{gev_pkg::NUM_AXES{gev_pkg::AXIS_RESET}};
	logic [gev_pkg::AXIS_W-1:0]                        gen_lo      =
		gev_pkg::LOWER_THRESH_INIT;
	logic [gev_pkg::AXIS_W-1:0]                        gen_hi      =
		gev_pkg::UPPER_THRESH_INIT;

	// Driver scratch.
	pad_action_t head;
	pad_action_t cur_sample;
	logic        fire_in;
	logic        fire_cfg;
	logic        next_in_valid;
	logic        next_cfg_valid;
	int          quiet_cycles;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Generous ceiling: a few hundred samples of up to 24 events each, with
	// heavy stalls, finish well inside this.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic void log_fault(input string msg);
		faults++;
		if (faults <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// Works out the events one accepted sample causes and moves the state on.
	// Axes come first, each checked low press, low release, high press, high
	// release; then the buttons from bit 0, press before release.
	task automatic derive_key_events(input pad_action_t s);
		key_event_t                        found[$];
		logic [gev_pkg::INPUT_BUTTONS-1:0] now_pressed;
		logic                              now_low, was_low, now_high, was_high;
		logic [gev_pkg::CODE_W-1:0]        low_code;
		key_event_t                        ev;

		// An invalid sample is swallowed and leaves the state alone.
		if (!s.sample_valid)
			return;

		for (int a = 0; a < gev_pkg::NUM_AXES; a++) begin
			low_code = gev_pkg::CODE_W'(gev_pkg::AXIS_CODE_BASE + 2 * a);
			now_low  = s.axes[a] <= lower_thr;
			was_low  = held_axes[a] <= lower_thr;
			now_high = s.axes[a] >= upper_thr;
			was_high = held_axes[a] >= upper_thr;
			// With overlapping thresholds both directions are judged on their
			// own, so a single axis may raise a low and a high event together.
			if (now_low && !was_low)
				found.push_back('{1'b1, low_code, 1'b0});
			if (!now_low && was_low)
				found.push_back('{1'b0, low_code, 1'b0});
			if (now_high && !was_high)
				found.push_back('{1'b1, low_code + 1'b1, 1'b0});
			if (!now_high && was_high)
				found.push_back('{1'b0, low_code + 1'b1, 1'b0});
			held_axes[a] = s.axes[a];
		end

		// Buttons are active low on the pins.
		now_pressed = ~s.buttons;
		for (int b = 0; b < gev_pkg::INPUT_BUTTONS; b++) begin
			if (now_pressed[b] && !held_buttons[b])
				found.push_back('{1'b1, gev_pkg::CODE_W'(b), 1'b0});
			if (!now_pressed[b] && held_buttons[b])
				found.push_back('{1'b0, gev_pkg::CODE_W'(b), 1'b0});
		end
		held_buttons = now_pressed;

		// A sample with no change gives no beat at all.
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[i]) begin
			ev = found[i];
			key_events_due.push_back(ev);
		end
	endtask

	// Driver. A beat that is offered stays on the bus untouched until it is
	// taken; only then is the next action looked at.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid       <= 1'b0;
			cfg_valid      <= 1'b0;
			quiet_cycles   = 0;
			held_buttons   = '0;
			held_axes      = {gev_pkg::NUM_AXES{gev_pkg::AXIS_RESET}};
			lower_thr      = gev_pkg::LOWER_THRESH_INIT;
			upper_thr      = gev_pkg::UPPER_THRESH_INIT;
		end else begin
			fire_in  = in_valid && in_ready;
			fire_cfg = cfg_valid && cfg_ready;
			if (fire_in)
				derive_key_events(cur_sample);
			if (fire_cfg) begin
				if (cfg_index == gev_pkg::CFG_LOWER_THRESHOLD)
					lower_thr = cfg_data;
				else
					upper_thr = cfg_data;
			end

			if ((in_valid && !fire_in) || (cfg_valid && !fire_cfg)) begin
				// Still waiting for ready: hold everything as it is.
			end else begin
				next_in_valid  = 1'b0;
				next_cfg_valid = 1'b0;
				if (pending.size() > 0) begin
					head = pending[0];
					case (head.kind)
						ACT_SAMPLE: begin
							// The sender idles at random; otherwise the next
							// sample goes straight onto the bus.
							if ($urandom_range(99) >= send_idle_pct) begin
								cur_sample = pending.pop_front();
								sample_valid <= cur_sample.sample_valid;
								buttons_raw  <= cur_sample.buttons;
								right_x      <= cur_sample.axes[0];
								right_y      <= cur_sample.axes[1];
								left_x       <= cur_sample.axes[2];
								left_y       <= cur_sample.axes[3];
								next_in_valid = 1'b1;
							end
						end
						ACT_CFG: begin
							head = pending.pop_front();
							cfg_index <= head.cfg_idx;
							cfg_data  <= head.cfg_val;
							next_cfg_valid = 1'b1;
						end
						ACT_DRAIN: begin
							// Hold back until every expected event has come,
							// then wait on while all is quiet, for samples that
							// cause nothing but may still be inside the block.
							if (key_events_due.size() == 0 && !fire_in) begin
								if (quiet_cycles >= DRAIN_SETTLE) begin
									head = pending.pop_front();
									quiet_cycles = 0;
								end else begin
									quiet_cycles++;
								end
							end else begin
								quiet_cycles = 0;
							end
						end
						default: begin
							head = pending.pop_front();
							send_idle_pct  = head.idle_pct;
							recv_stall_pct = head.stall_pct;
						end
					endcase
				end
				in_valid  <= next_in_valid;
				cfg_valid <= next_cfg_valid;
			end
		end
	end

	// Monitor. Each event beat is matched against the oldest expected event,
	// field by field; ready is dropped at random to stall the block.
	always @(posedge clk or negedge arst_n) begin
		key_event_t got;
		key_event_t want;

		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{is_press, event_code, last};
				if (key_events_due.size() == 0) begin
					log_fault($sformatf("unexpected event: press %0b code %0d last %0b",
						got.is_press, got.code, got.last));
				end else begin
					want = key_events_due.pop_front();
					if (got.is_press !== want.is_press || got.code !== want.code ||
							got.last !== want.last)
						log_fault($sformatf({"event mismatch: expected press %0b code %0d ",
							"last %0b, got press %0b code %0d last %0b"},
							want.is_press, want.code, want.last,
							got.is_press, got.code, got.last));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic queue_sample(input logic valid, input logic [15:0] btn,
			input logic [7:0] rx, input logic [7:0] ry,
			input logic [7:0] lx, input logic [7:0] ly);
		pad_action_t act;

		act              = '0;
		act.kind         = ACT_SAMPLE;
		act.sample_valid = valid;
		act.buttons      = btn;
		act.axes         = {ly, lx, ry, rx};
		pending.push_back(act);
		if (valid) begin
			gen_buttons = btn;
			gen_axes    = act.axes;
		end
	endtask

	task automatic queue_drain();
		pad_action_t act;

		act      = '0;
		act.kind = ACT_DRAIN;
		pending.push_back(act);
	endtask

	// Threshold writes only go in once the block has gone quiet.
	task automatic queue_cfg(input logic idx, input logic [7:0] val);
		pad_action_t act;

		queue_drain();
		act         = '0;
		act.kind    = ACT_CFG;
		act.cfg_idx = idx;
		act.cfg_val = val;
		pending.push_back(act);
		if (idx == gev_pkg::CFG_LOWER_THRESHOLD)
			gen_lo = val;
		else
			gen_hi = val;
	endtask

	task automatic queue_phase(input int idle, input int stall);
		pad_action_t act;

		act           = '0;
		act.kind      = ACT_PHASE;
		act.idle_pct  = 7'(idle);
		act.stall_pct = 7'(stall);
		pending.push_back(act);
	endtask

	// Axis values cluster round the thresholds so that crossings are common.
	function automatic logic [7:0] pick_axis(input logic [7:0] was);
		int r;

		r = $urandom_range(99);
		if (r < 25)
			return was;
		else if (r < 45)
			return 8'(int'(gen_lo) + int'($urandom_range(4)) - 2);
		else if (r < 65)
			return 8'(int'(gen_hi) + int'($urandom_range(4)) - 2);
		else if (r < 72)
			return 8'h00;
		else if (r < 79)
			return 8'hFF;
		else if (r < 85)
			return gev_pkg::AXIS_RESET;
		else
			return 8'($urandom);
	endfunction

	task automatic queue_random_sample();
		logic [15:0] btn;
		logic [7:0]  ax [gev_pkg::NUM_AXES];
		int          r;

		r = $urandom_range(99);
		if (r < 8) begin
			// Noise: a failed read with arbitrary contents.
			queue_sample(1'b0, 16'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
		end else begin
			r = $urandom_range(99);
			if (r < 45) begin
				btn = gen_buttons;
				repeat ($urandom_range(1, 3))
					btn[$urandom_range(gev_pkg::INPUT_BUTTONS - 1)] ^= 1'b1;
			end else if (r < 70)
				btn = 16'($urandom);
			else if (r < 82)
				btn = gen_buttons;
			else if (r < 88)
				btn = 16'h0000;
			else if (r < 94)
				btn = 16'hFFFF;
			else
				btn = gen_buttons ^ 16'($urandom);
			for (int a = 0; a < gev_pkg::NUM_AXES; a++)
				ax[a] = pick_axis(gen_axes[a]);
			queue_sample(1'b1, btn, ax[0], ax[1], ax[2], ax[3]);
		end
	endtask

	initial begin
		int idle, stall;
		logic [7:0] lo, hi;

		// Directed part, starting from the reset thresholds written back.
		queue_cfg(gev_pkg::CFG_LOWER_THRESHOLD, gev_pkg::LOWER_THRESH_INIT);
		queue_cfg(gev_pkg::CFG_UPPER_THRESHOLD, gev_pkg::UPPER_THRESH_INIT);
		// Nothing changed against the reset state: no events.
		queue_sample(1'b1, 16'hFFFF, 8'd127, 8'd127, 8'd127, 8'd127);
		// Every button pressed and every axis pushed to an end.
		queue_sample(1'b1, 16'h0000, 8'd0, 8'd255, 8'd0, 8'd255);
		// A failed read full of changes must be ignored.
		queue_sample(1'b0, 16'hFFFF, 8'd127, 8'd127, 8'd127, 8'd127);
		queue_sample(1'b1, 16'h0000, 8'd0, 8'd255, 8'd0, 8'd255);
		// Everything released and every axis flipped across.
		queue_sample(1'b1, 16'hFFFF, 8'd255, 8'd0, 8'd255, 8'd0);
		// Values sitting exactly on and just beside the thresholds.
		queue_sample(1'b1, 16'hFFFE, 8'd50, 8'd200, 8'd51, 8'd199);
		queue_sample(1'b1, 16'h7FFF, 8'd51, 8'd199, 8'd50, 8'd200);
		queue_sample(1'b1, 16'hAAAA, 8'd127, 8'd127, 8'd127, 8'd127);
		queue_sample(1'b1, 16'h5555, 8'd127, 8'd127, 8'd127, 8'd127);
		// Overlapping thresholds: going from low-only to high-only raises a
		// release and a press on every axis, which with all sixteen buttons
		// changing gives the longest burst of events.
		queue_cfg(gev_pkg::CFG_LOWER_THRESHOLD, 8'd200);
		queue_cfg(gev_pkg::CFG_UPPER_THRESHOLD, 8'd50);
		queue_sample(1'b1, 16'hFFFF, 8'd0, 8'd0, 8'd255, 8'd255);
		queue_sample(1'b1, 16'h0000, 8'd255, 8'd255, 8'd0, 8'd0);
		queue_sample(1'b1, 16'hFFFF, 8'd127, 8'd127, 8'd127, 8'd127);
		// Thresholds at the far ends of their range.
		queue_cfg(gev_pkg::CFG_LOWER_THRESHOLD, 8'd0);
		queue_cfg(gev_pkg::CFG_UPPER_THRESHOLD, 8'd255);
		queue_sample(1'b1, 16'h8001, 8'd0, 8'd255, 8'd1, 8'd254);
		queue_sample(1'b1, 16'hFFFF, 8'd255, 8'd0, 8'd0, 8'd255);
		queue_cfg(gev_pkg::CFG_LOWER_THRESHOLD, 8'd255);
		queue_cfg(gev_pkg::CFG_UPPER_THRESHOLD, 8'd0);
		queue_sample(1'b1, 16'hFFFF, 8'd127, 8'd127, 8'd0, 8'd255);
		queue_sample(1'b0, 16'h0000, 8'd0, 8'd0, 8'd0, 8'd0);
		// Equal thresholds: a value on the line is both low and high.
		queue_cfg(gev_pkg::CFG_LOWER_THRESHOLD, 8'd128);
		queue_cfg(gev_pkg::CFG_UPPER_THRESHOLD, 8'd128);
		queue_sample(1'b1, 16'h1234, 8'd128, 8'd127, 8'd129, 8'd128);
		queue_sample(1'b1, 16'hEDCB, 8'd127, 8'd128, 8'd128, 8'd129);

		// Random part, one phase per idling pattern, each with its own
		// thresholds and a pause halfway in which the sender waits for the
		// block to empty.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					idle = 0;  stall = 0;
					lo = gev_pkg::LOWER_THRESH_INIT;
					hi = gev_pkg::UPPER_THRESH_INIT;
				end
				1: begin
					idle = 52; stall = 0;  lo = 8'd0; hi = 8'd255;
				end
				2: begin
					idle = 0;  stall = 52;
					lo = 8'($urandom_range(128, 255));
					hi = 8'($urandom_range(0, 127));
				end
				default: begin
					idle = 35; stall = 35;
					lo = 8'($urandom_range(1, 254));
					hi = lo;
				end
			endcase
			queue_cfg(gev_pkg::CFG_LOWER_THRESHOLD, lo);
			queue_cfg(gev_pkg::CFG_UPPER_THRESHOLD, hi);
			queue_phase(idle, stall);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					queue_drain();
				queue_random_sample();
			end
		end
		queue_drain();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Look at the bench state between edges, where it is settled.
		do
			@(negedge clk);
		while (pending.size() != 0 || in_valid || cfg_valid || key_events_due.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		if (key_events_due.size() != 0)
			log_fault($sformatf("%0d expected events never arrived", key_events_due.size()));

		if (faults == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
sv/gev_pkg.sv
sv/gev_axis_lane.sv
sv/gev_serializer.sv
sv/gamepad_event_generator.sv
dv/testbench.sv
